// ===== sv/assert_macros.svh =====
// Assertion macros shared by the PID controller RTL.
// Needs signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PIDIS_ASSERT_NOW(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pidis assertion failed");

// next-cycle implication
`define PIDIS_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("pidis assertion failed");

`endif

// ===== sv/pidis_pkg.sv =====
// Package of the positional PID with integral separation.
// Types, register map and reset values; no dependencies.
package pidis_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int GAIN_W = 16;
	localparam int ILIM_W = 31;
	localparam int OLIM_W = 15;
	localparam int THR_W  = 17;
	localparam int ACC_W  = 32;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [OLIM_W-1:0] OLIM_RST = 15'h7fff;
	localparam logic [THR_W-1:0]  THR_RST  = 17'h1ffff;

	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_ILIMIT    = 3'd3,
		REG_OLIMIT    = 3'd4,
		REG_SEP_EN    = 3'd5,
		REG_SEP_THR   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [ILIM_W-1:0]        integral_limit;
		logic [OLIM_W-1:0]        output_limit;
		logic                     separation_enable;
		logic [THR_W-1:0]         separation_threshold;
	} cfg_t;

endpackage

// ===== sv/pidis_if.sv =====
// Stream interfaces of the PID controller: sample beats in, drive beats out.
// Depends on pidis_pkg.
interface pidis_in_if #(
	parameter int W = pidis_pkg::SAMPLE_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] target;
	logic signed [W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidis_out_if #(
	parameter int W = pidis_pkg::SAMPLE_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] drive;
	logic                clamped;

	modport source (output valid, output drive, output clamped, input ready);
	modport sink (input valid, input drive, input clamped, output ready);
endinterface

// ===== sv/pidis_regs.sv =====
// APB configuration registers of the PID controller.
// Depends on pidis_pkg.
module pidis_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidis_pkg::APB_AW-1:0]  paddr,
	input  logic [pidis_pkg::APB_DW-1:0]  pwdata,
	output logic [pidis_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output pidis_pkg::cfg_t               cfg
);
	pidis_pkg::cfg_t     cfg_q;
	pidis_pkg::reg_idx_t idx;
	logic                wr;

	assign pready = 1'b1;
	assign idx    = pidis_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p               <= '0;
			cfg_q.gain_i               <= '0;
			cfg_q.gain_d               <= '0;
			cfg_q.integral_limit       <= '0;
			cfg_q.output_limit         <= pidis_pkg::OLIM_RST;
			cfg_q.separation_enable    <= 1'b0;
			cfg_q.separation_threshold <= pidis_pkg::THR_RST;
		end else if (wr) begin
			unique case (idx)
				pidis_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= pwdata[pidis_pkg::GAIN_W-1:0];
				end
				pidis_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= pwdata[pidis_pkg::GAIN_W-1:0];
				end
				pidis_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= pwdata[pidis_pkg::GAIN_W-1:0];
				end
				pidis_pkg::REG_ILIMIT: begin
					cfg_q.integral_limit <= pwdata[pidis_pkg::ILIM_W-1:0];
				end
				pidis_pkg::REG_OLIMIT: begin
					cfg_q.output_limit <= pwdata[pidis_pkg::OLIM_W-1:0];
				end
				pidis_pkg::REG_SEP_EN: begin
					cfg_q.separation_enable <= pwdata[0];
				end
				pidis_pkg::REG_SEP_THR: begin
					cfg_q.separation_threshold <= pwdata[pidis_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			pidis_pkg::REG_GAIN_P:  prdata = pidis_pkg::APB_DW'(unsigned'(cfg_q.gain_p));
			pidis_pkg::REG_GAIN_I:  prdata = pidis_pkg::APB_DW'(unsigned'(cfg_q.gain_i));
			pidis_pkg::REG_GAIN_D:  prdata = pidis_pkg::APB_DW'(unsigned'(cfg_q.gain_d));
			pidis_pkg::REG_ILIMIT:  prdata = pidis_pkg::APB_DW'(cfg_q.integral_limit);
			pidis_pkg::REG_OLIMIT:  prdata = pidis_pkg::APB_DW'(cfg_q.output_limit);
			pidis_pkg::REG_SEP_EN:  prdata = pidis_pkg::APB_DW'(cfg_q.separation_enable);
			pidis_pkg::REG_SEP_THR: prdata = pidis_pkg::APB_DW'(cfg_q.separation_threshold);
			default:                prdata = '0;
		endcase
	end
endmodule

// ===== sv/pidis_core.sv =====
// Datapath of the PID controller: input register, one pass of P/I/D math, result register.
// Holds the integral accumulator and last error. Depends on pidis_pkg, pidis_if, assert_macros.svh.
`include "assert_macros.svh"

module pidis_core #(
	parameter int SAMPLE_WIDTH   = pidis_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidis_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pidis_pkg::cfg_t cfg,
	pidis_in_if.sink        sample,
	pidis_out_if.source     result
);
	localparam int W    = SAMPLE_WIDTH;
	localparam int F    = GAIN_FRAC_BITS;
	localparam int GW   = pidis_pkg::GAIN_W;
	localparam int AW   = pidis_pkg::ACC_W;
	localparam int EW   = W + 1;
	localparam int DW   = W + 2;
	localparam int PW   = EW + GW;
	localparam int DPW  = DW + GW;
	localparam int ISW  = ((PW > AW) ? PW : AW) + 1;
	localparam int SW   = ((DPW > AW) ? DPW : AW) + 2;
	localparam int THW  = ((EW > pidis_pkg::THR_W) ? EW : pidis_pkg::THR_W);
	localparam int LW   = ((W > pidis_pkg::OLIM_W) ? W : pidis_pkg::OLIM_W);

	logic                valid_s1;
	logic signed [W-1:0] target_s1;
	logic signed [W-1:0] measured_s1;
	logic                valid_s2;
	logic signed [W-1:0] drive_s2;
	logic                clamped_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [EW-1:0] prev_err_q;

	logic                 adv;
	logic signed [EW-1:0]  err;
	logic signed [DW-1:0]  diff;
	logic signed [PW-1:0]  p_prod, i_prod;
	logic signed [DPW-1:0] d_prod;
	logic signed [PW-1:0]  p_sh, i_sh;
	logic signed [DPW-1:0] d_sh;
	logic signed [ISW-1:0] acc_sum, ilim;
	logic signed [ISW-1:0] acc_cl;
	logic signed [AW-1:0]  acc_next;
	logic [EW-1:0]         mag;
	logic                  sep;
	logic [LW-1:0]         smax, olim, lim_o;
	logic signed [SW-1:0]  olim_s, sum, sum_cl;
	logic                  ohit;

	assign adv          = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv;
	assign result.valid   = valid_s2;
	assign result.drive   = drive_s2;
	assign result.clamped = clamped_s2;

	// error and gain products
	assign err    = EW'(target_s1) - EW'(measured_s1);
	assign diff   = DW'(err) - DW'(prev_err_q);
	assign p_prod = PW'(cfg.gain_p) * PW'(err);
	assign i_prod = PW'(cfg.gain_i) * PW'(err);
	assign d_prod = DPW'(cfg.gain_d) * DPW'(diff);
	assign p_sh   = p_prod >>> F;
	assign i_sh   = i_prod >>> F;
	assign d_sh   = d_prod >>> F;

	// integral accumulate and clamp
	assign acc_sum = ISW'(acc_q) + ISW'(i_sh);
	assign ilim    = ISW'(signed'({1'b0, cfg.integral_limit}));
	always_comb begin
		priority if (acc_sum > ilim) begin
			acc_cl = ilim;
		end else if (acc_sum < -ilim) begin
			acc_cl = -ilim;
		end else begin
			acc_cl = acc_sum;
		end
	end
	assign acc_next = AW'(acc_cl);

	// separation by error magnitude
	assign mag = err[EW-1] ? EW'(-err) : EW'(err);
	assign sep = cfg.separation_enable && (THW'(mag) >= THW'(cfg.separation_threshold));

	// output sum and saturation
	assign smax   = LW'({1'b0, {(W-1){1'b1}}});
	assign olim   = LW'(cfg.output_limit);
	assign lim_o  = (olim < smax) ? olim : smax;
	assign olim_s = SW'(signed'({1'b0, lim_o}));
	assign sum    = SW'(p_sh) + SW'(d_sh) + (sep ? SW'(0) : SW'(acc_next));
	always_comb begin
		ohit = 1'b1;
		priority if (sum > olim_s) begin
			sum_cl = olim_s;
		end else if (sum < -olim_s) begin
			sum_cl = -olim_s;
		end else begin
			sum_cl = sum;
			ohit   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			acc_q      <= '0;
			prev_err_q <= '0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (adv) begin
				valid_s2   <= 1'b1;
				acc_q      <= acc_next;
				prev_err_q <= err;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			target_s1   <= sample.target;
			measured_s1 <= sample.measured;
		end
		if (adv) begin
			drive_s2   <= W'(sum_cl);
			clamped_s2 <= ohit;
		end
	end

	`PIDIS_ASSERT_NEXT(a_prev_err_tracks, adv, prev_err_q == $past(err))
	`PIDIS_ASSERT_NEXT(a_state_holds, !adv, $stable(acc_q) && $stable(prev_err_q))
	`PIDIS_ASSERT_NOW(a_ready_when_drain, !valid_s2 || result.ready, sample.ready)
	`PIDIS_ASSERT_NEXT(a_result_loads, adv, valid_s2)
endmodule

// ===== sv/positional_pid_integral_separation_top.sv =====
// Positional PID with integral separation: a sample beat goes through the input register and
// the result register to a drive beat; one beat accepted per cycle while result is ready.
// The error, three gain products, integral clamp and output saturation run in one pass
// between the input register and the result register; a stalled result holds the input side.
// arst_n clears the accumulator, last error, valid flags and registers to their defaults.
module positional_pid_integral_separation_top #(
	parameter int SAMPLE_WIDTH   = pidis_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidis_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidis_pkg::APB_AW-1:0]  paddr,
	input  logic [pidis_pkg::APB_DW-1:0]  pwdata,
	output logic [pidis_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	pidis_in_if.sink                      sample,
	pidis_out_if.source                   result
);
	pidis_pkg::cfg_t cfg;

	pidis_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidis_core #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);
endmodule
